FILE: rtl/core/sd_spi_command_and_read_engine_assert.svh
// Assertion macros shared by the SD SPI engine checkers.
`ifndef SD_SPI_COMMAND_AND_READ_ENGINE_ASSERT_SVH
`define SD_SPI_COMMAND_AND_READ_ENGINE_ASSERT_SVH

// Condition a must hold together with c in the same cycle.
`define SDSPI_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("sd spi check failed: same-cycle rule");

// Condition a in one cycle requires c in the next.
`define SDSPI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("sd spi check failed: next-cycle rule");

`endif

FILE: rtl/core/sdspi_pkg.sv
// Package: types, codes and CRC helpers of the SD SPI command and read engine.
package sdspi_pkg;

    localparam int BLOCK_BYTES     = 512;
    localparam int REGISTER_BYTES  = 16;
    localparam int CNT_W           = $clog2(BLOCK_BYTES + 1);
    localparam int CMD_FRAME_BYTES = 6;
    localparam int OB_CNT_W        = $clog2(CMD_FRAME_BYTES + 1);

    localparam logic [5:0] CMD_SEND_CSD = 6'd9;
    localparam logic [5:0] CMD_SEND_CID = 6'd10;
    localparam logic [5:0] CMD_READ_BLK = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLK = 6'd24;

    localparam logic [7:0] CMD_START    = 8'h40;
    localparam logic [7:0] TOKEN_START  = 8'hfe;
    localparam logic [7:0] BYTE_IDLE    = 8'hff;

    localparam logic REQ_ISSUE = 1'b0;
    localparam logic REQ_RX    = 1'b1;

    localparam logic [3:0] STAT_OK        = 4'd0;
    localparam logic [3:0] STAT_BAD_TOKEN = 4'd8;
    localparam logic [3:0] STAT_DATA_CRC  = 4'd9;
    localparam logic [3:0] STAT_MAX       = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_R1,
        PH_TOKEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_R1   = 2'd1,
        KIND_DATA = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    // One result (or a whole command frame) handed to the output buffer.
    typedef struct packed {
        t_kind            kind;
        logic [4:0][7:0]  bytes;
        logic [3:0]       status;
        logic             last;
    } t_ob_item;

    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ b[i];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ 7'h09;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Highest set bit wins: bit 6 gives 1, bit 0 gives 7.
    function automatic logic [3:0] r1_status(input logic [6:0] r1);
        logic [3:0] st;
        st = STAT_OK;
        for (int i = 0; i < 7; i++) begin
            if (r1[i]) begin
                st = 4'(7 - i);
            end
        end
        return st;
    endfunction

endpackage

FILE: rtl/core/sd_spi_command_and_read_engine.sv
// SD SPI command and read engine, top level.
//
// Each transfer on the input side is either an issue request or one byte
// received from the card. A received byte passes through the input register
// and the combinational decode stage into the output buffer register, so bytes
// are taken one per cycle while the output buffer can accept. An issue request
// yields a six-byte command frame that leaves the output buffer one byte per
// cycle while the output is ready, with CRC7 built up a byte per cycle as the
// frame drains; while the frame drains one further request is held in the
// input register and input ready drops. The configuration register (byte
// addressing for commands 17 and 24) is always ready.
module sd_spi_command_and_read_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // cmd_index[5:0], cmd_arg[37:6], rx_byte[45:38], zero pad
    input  logic [0:0]  i_s_axis_tuser,   // req_type[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // out_byte[7:0], status[11:8], zero pad
    output logic [1:0]  o_m_axis_tuser,   // out_kind[1:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data        // byte_addressed[0]
);
    import sdspi_pkg::*;

    logic        r_byte_addr;
    logic        r_a_valid;
    logic        r_a_req;
    logic [5:0]  r_a_cmd;
    logic [31:0] r_a_arg;
    logic [7:0]  r_a_rx;

    t_phase           r_phase, n_phase;
    logic             r_is_blk, n_is_blk;
    logic             r_rd_pend, n_rd_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc16, n_crc16;
    logic [7:0]       r_crc_hi, n_crc_hi;

    logic             ob_free;
    logic             adv;
    logic             load;
    t_ob_item         item;
    logic [31:0]      arg;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] len;
    logic             go;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_a_valid || ob_free;
    assign adv             = r_a_valid && ob_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_addr <= 1'b0;
        end else if (i_cfg_valid) begin
            r_byte_addr <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_a_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_a_req <= i_s_axis_tuser[0];
            r_a_cmd <= i_s_axis_tdata[5:0];
            r_a_arg <= i_s_axis_tdata[37:6];
            r_a_rx  <= i_s_axis_tdata[45:38];
        end
    end

    assign cnt_inc = r_count + CNT_W'(1);
    assign len     = r_is_blk ? CNT_W'(BLOCK_BYTES) : CNT_W'(REGISTER_BYTES);
    assign go      = r_rd_pend && (!r_is_blk || (r_a_rx == 8'h00));
    assign arg     = (((r_a_cmd == CMD_READ_BLK) || (r_a_cmd == CMD_WRITE_BLK)) && r_byte_addr) ?
                     {r_a_arg[22:0], 9'b0} : r_a_arg;

    always_comb begin
        n_phase     = r_phase;
        n_is_blk    = r_is_blk;
        n_rd_pend   = r_rd_pend;
        n_count     = r_count;
        n_crc16     = r_crc16;
        n_crc_hi    = r_crc_hi;
        load        = 1'b0;
        item.kind   = KIND_CMD;
        item.bytes  = '0;
        item.bytes[0] = r_a_rx;
        item.status = STAT_OK;
        item.last   = 1'b0;
        if (adv) begin
            if (r_a_req == REQ_ISSUE) begin
                load          = 1'b1;
                item.kind     = KIND_CMD;
                item.bytes[0] = CMD_START | {2'b00, r_a_cmd};
                item.bytes[1] = arg[31:24];
                item.bytes[2] = arg[23:16];
                item.bytes[3] = arg[15:8];
                item.bytes[4] = arg[7:0];
                item.last     = 1'b1;
                n_rd_pend     = (r_a_cmd == CMD_SEND_CSD) || (r_a_cmd == CMD_SEND_CID) ||
                                (r_a_cmd == CMD_READ_BLK);
                n_is_blk      = (r_a_cmd == CMD_READ_BLK);
                n_count       = '0;
                n_crc16       = '0;
                n_crc_hi      = '0;
                n_phase       = PH_R1;
            end else begin
                case (r_phase)
                    PH_R1: begin
                        if (!r_a_rx[7]) begin
                            load        = 1'b1;
                            item.kind   = KIND_R1;
                            item.status = r1_status(r_a_rx[6:0]);
                            item.last   = !go;
                            n_phase     = go ? PH_TOKEN : PH_IDLE;
                        end
                    end
                    PH_TOKEN: begin
                        if (r_a_rx == TOKEN_START) begin
                            n_count = '0;
                            n_crc16 = '0;
                            n_phase = PH_DATA;
                        end else if (r_a_rx != BYTE_IDLE) begin
                            load        = 1'b1;
                            item.kind   = KIND_DONE;
                            item.status = STAT_BAD_TOKEN;
                            item.last   = 1'b1;
                            n_phase     = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        load      = 1'b1;
                        item.kind = KIND_DATA;
                        n_crc16   = crc16_byte(r_crc16, r_a_rx);
                        n_count   = cnt_inc;
                        if (cnt_inc >= len) begin
                            n_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = r_a_rx;
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        load          = 1'b1;
                        item.kind     = KIND_DONE;
                        item.bytes[0] = 8'h00;
                        item.status   = ({r_crc_hi, r_a_rx} == r_crc16) ? STAT_OK : STAT_DATA_CRC;
                        item.last     = 1'b1;
                        n_phase       = PH_IDLE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_blk  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_count   <= '0;
            r_crc16   <= '0;
            r_crc_hi  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_is_blk  <= n_is_blk;
            r_rd_pend <= n_rd_pend;
            r_count   <= n_count;
            r_crc16   <= n_crc16;
            r_crc_hi  <= n_crc_hi;
        end
    end

    sdspi_outbuf u_outbuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_item          (item),
        .o_free          (ob_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: rtl/core/sdspi_outbuf.sv
// Output buffer: holds one result or a command frame and appends the CRC7 byte.
module sdspi_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sdspi_pkg::t_ob_item i_item,
    output logic                o_free,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [15:0]         o_m_axis_tdata,   // out_byte[7:0], status[11:8], zero pad
    output logic [1:0]          o_m_axis_tuser,   // out_kind[1:0]
    output logic                o_m_axis_tlast
);
    import sdspi_pkg::*;

    logic [OB_CNT_W-1:0] r_cnt, n_cnt;
    logic [4:0][7:0]     r_bytes, n_bytes;
    t_kind               r_kind, n_kind;
    logic [3:0]          r_status, n_status;
    logic                r_last, n_last;
    logic [6:0]          r_crc7, n_crc7;
    logic                xfer;
    logic [7:0]          out_byte;

    assign xfer     = (r_cnt != '0) && i_m_axis_tready;
    assign o_free   = (r_cnt == '0) || ((r_cnt == OB_CNT_W'(1)) && i_m_axis_tready);
    assign out_byte = ((r_kind == KIND_CMD) && (r_cnt == OB_CNT_W'(1))) ?
                      {r_crc7, 1'b1} : r_bytes[0];

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {4'h0, r_status, out_byte};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last && (r_cnt == OB_CNT_W'(1));

    always_comb begin
        n_cnt    = r_cnt;
        n_bytes  = r_bytes;
        n_kind   = r_kind;
        n_status = r_status;
        n_last   = r_last;
        n_crc7   = r_crc7;
        if (xfer) begin
            n_cnt   = r_cnt - OB_CNT_W'(1);
            n_bytes = {8'h00, r_bytes[4:1]};
            if ((r_kind == KIND_CMD) && (r_cnt != OB_CNT_W'(1))) begin
                n_crc7 = crc7_byte(r_crc7, r_bytes[0]);
            end
        end
        if (i_load) begin
            n_cnt    = (i_item.kind == KIND_CMD) ? OB_CNT_W'(CMD_FRAME_BYTES) : OB_CNT_W'(1);
            n_bytes  = i_item.bytes;
            n_kind   = i_item.kind;
            n_status = i_item.status;
            n_last   = i_item.last;
            n_crc7   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bytes  <= n_bytes;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_last   <= n_last;
        r_crc7   <= n_crc7;
    end

endmodule

FILE: rtl/core/sdspi_checker.sv
// Port-level checker for the SD SPI engine, bound to the top level.
`include "sd_spi_command_and_read_engine_assert.svh"

module sdspi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import sdspi_pkg::*;

    `SDSPI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    `SDSPI_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[11:8] <= STAT_MAX) && (o_m_axis_tdata[15:12] == 4'h0))
    `SDSPI_ASSERT_NOW(a_data_plain, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == KIND_DATA), (o_m_axis_tdata[11:8] == STAT_OK) && !o_m_axis_tlast)
    `SDSPI_ASSERT_NOW(a_cmd_stop_bit, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == KIND_CMD) && o_m_axis_tlast, o_m_axis_tdata[0])
    `SDSPI_ASSERT_NOW(a_done_last, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == KIND_DONE), o_m_axis_tlast)

endmodule

bind sd_spi_command_and_read_engine sdspi_checker u_sdspi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

FILE: dv/tb_top.sv
// Testbench for the SD SPI command framer and read engine: directed table plus random transactions.
`timescale 1ns / 100ps

module tb_top;
    import sdspi_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int PHASE_ITEMS  = 88;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIR_ROWS     = 25;

    localparam logic [3:0] ST_PARAM      = 4'd1;
    localparam logic [3:0] ST_CMD_CRC    = 4'd4;
    localparam logic [3:0] ST_ILLEGAL    = 4'd5;
    localparam logic [3:0] ST_ERASE_RST  = 4'd6;
    localparam logic [3:0] ST_IDLE_STATE = 4'd7;

    typedef struct {
        logic        req;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  rx;
    } t_xfer;

    typedef struct {
        t_kind      kind;
        logic [7:0] octet;
        logic [3:0] status;
        logic       last_b;
    } t_result;

    // typed = 1: the final result of the row is given here
    typedef struct {
        logic        req;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  rx;
        bit          typed;
        t_kind       kind;
        logic [7:0]  octet;
        logic [3:0]  status;
        logic        last_b;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_valid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = '0;

    // predictor state
    t_phase      ph_q = PH_IDLE;
    logic        byte_addr = 1'b0;
    logic        p_read = 1'b0;
    logic        p_block = 1'b0;
    logic [5:0]  p_cmd = '0;
    int          p_cnt = 0;
    logic [15:0] p_crc = '0;
    logic [7:0]  p_crc_hi = '0;

    t_result pending_results[$];

    int cycle_cnt = 0;
    int err_cnt = 0;
    int n_in = 0;
    int n_counted = 0;
    int n_checked = 0;
    int n_full_reads = 0;
    int n_cfg = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_used = 1'b0;
    int hold_left = 0;

    t_row dir_rows [DIR_ROWS] = '{
        '{REQ_RX,    6'd0,  32'h0,        8'h01, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_ISSUE, 6'd0,  32'h0,        8'h00, 1'b1, KIND_CMD,  8'h95, STAT_OK,        1'b1},
        '{REQ_RX,    6'd0,  32'h0,        8'hff, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h01, 1'b1, KIND_R1,   8'h01, ST_IDLE_STATE,  1'b1},
        '{REQ_ISSUE, 6'd8,  32'h1aa,      8'h00, 1'b1, KIND_CMD,  8'h87, STAT_OK,        1'b1},
        '{REQ_RX,    6'd0,  32'h0,        8'h7f, 1'b1, KIND_R1,   8'h7f, ST_PARAM,       1'b1},
        '{REQ_ISSUE, 6'd63, 32'hffffffff, 8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h04, 1'b1, KIND_R1,   8'h04, ST_ILLEGAL,     1'b1},
        '{REQ_ISSUE, 6'd9,  32'h0,        8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h00, 1'b1, KIND_R1,   8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'hff, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h00, 1'b1, KIND_DONE, 8'h00, STAT_BAD_TOKEN, 1'b1},
        '{REQ_ISSUE, 6'd17, 32'h0,        8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h02, 1'b1, KIND_R1,   8'h02, ST_ERASE_RST,   1'b1},
        '{REQ_ISSUE, 6'd10, 32'h12345678, 8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h08, 1'b1, KIND_R1,   8'h08, ST_CMD_CRC,     1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'hfe, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'hab, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_ISSUE, 6'd24, 32'hffffffff, 8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h40, 1'b1, KIND_R1,   8'h40, ST_PARAM,       1'b1},
        '{REQ_ISSUE, 6'd17, 32'h1,        8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h00, 1'b1, KIND_R1,   8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'hc3, 1'b1, KIND_DONE, 8'hc3, STAT_BAD_TOKEN, 1'b1},
        '{REQ_ISSUE, 6'd10, 32'h0,        8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0},
        '{REQ_RX,    6'd0,  32'h0,        8'h00, 1'b0, KIND_CMD,  8'h00, STAT_OK,        1'b0}
    };

    sd_spi_command_and_read_engine u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("tb_top: timeout after %0d cycles", cycle_cnt);
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [6:0] frame_crc7(input logic [39:0] head);
        logic [6:0] r;
        logic       fb;
        r = '0;
        for (int k = 39; k >= 0; k--) begin
            fb = r[6] ^ head[k];
            r  = {r[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
        end
        return r;
    endfunction

    function automatic logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return r;
    endfunction

    // first set bit from bit 6 down decides
    function automatic logic [3:0] r1_code(input logic [7:0] r1);
        for (int k = 6; k >= 0; k--) begin
            if (r1[k]) begin
                return 4'(7 - k);
            end
        end
        return STAT_OK;
    endfunction

    task automatic push_result(input t_kind kind, input logic [7:0] octet,
                               input logic [3:0] status, input logic last_b);
        t_result r;
        r.kind   = kind;
        r.octet  = octet;
        r.status = status;
        r.last_b = last_b;
        pending_results.push_back(r);
    endtask

    task automatic predict_card_transfer(input t_xfer x);
        logic [31:0]     arg;
        logic [5:0][7:0] f;
        logic            go;
        if (x.req == REQ_ISSUE) begin
            arg = x.arg;
            if ((x.cmd == CMD_READ_BLK || x.cmd == CMD_WRITE_BLK) && byte_addr) begin
                arg = {arg[22:0], 9'd0};
            end
            f[0] = CMD_START | {2'b00, x.cmd};
            f[1] = arg[31:24];
            f[2] = arg[23:16];
            f[3] = arg[15:8];
            f[4] = arg[7:0];
            f[5] = {frame_crc7({f[0], f[1], f[2], f[3], f[4]}), 1'b1};
            for (int i = 0; i < CMD_FRAME_BYTES; i++) begin
                push_result(KIND_CMD, f[i], STAT_OK, i == CMD_FRAME_BYTES - 1);
            end
            p_cmd    = x.cmd;
            p_read   = (x.cmd == CMD_SEND_CSD || x.cmd == CMD_SEND_CID || x.cmd == CMD_READ_BLK);
            p_block  = (x.cmd == CMD_READ_BLK);
            p_cnt    = 0;
            p_crc    = '0;
            p_crc_hi = '0;
            ph_q     = PH_R1;
        end else begin
            case (ph_q)
                PH_R1: begin
                    if (!x.rx[7]) begin
                        go = p_read && (p_cmd != CMD_READ_BLK || x.rx == 8'h00);
                        push_result(KIND_R1, x.rx, r1_code(x.rx), !go);
                        ph_q = go ? PH_TOKEN : PH_IDLE;
                    end
                end
                PH_TOKEN: begin
                    if (x.rx == TOKEN_START) begin
                        p_cnt = 0;
                        p_crc = '0;
                        ph_q  = PH_DATA;
                    end else if (x.rx != BYTE_IDLE) begin
                        push_result(KIND_DONE, x.rx, STAT_BAD_TOKEN, 1'b1);
                        ph_q = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    p_crc = ccitt_next(p_crc, x.rx);
                    p_cnt++;
                    push_result(KIND_DATA, x.rx, STAT_OK, 1'b0);
                    if (p_cnt >= (p_block ? BLOCK_BYTES : REGISTER_BYTES)) begin
                        ph_q = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    p_crc_hi = x.rx;
                    ph_q     = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    push_result(KIND_DONE, 8'h00,
                                ({p_crc_hi, x.rx} == p_crc) ? STAT_OK : STAT_DATA_CRC, 1'b1);
                    ph_q = PH_IDLE;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what);
        if (err_cnt < 20) begin
            $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, what);
        end
        err_cnt++;
    endtask

    task automatic check_result();
        t_result want;
        n_checked++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h", m_tuser,
                                      m_tdata[7:0]));
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser != want.kind) begin
            report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
        end
        if (m_tdata[7:0] != want.octet) begin
            report_mismatch($sformatf("byte %02h, want %02h", m_tdata[7:0], want.octet));
        end
        if (m_tdata[11:8] != want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", m_tdata[11:8], want.status));
        end
        if (m_tlast != want.last_b) begin
            report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last_b));
        end
    endtask

    // long output hold-off, counted down here
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: checking and random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_valid && m_tready) begin
                check_result();
            end
            if ((hold_arm && !hold_used) || (hold_left != 0)) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_xfer(input t_xfer x, input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_tuser <= x.req;
        s_tdata <= {2'b00, x.rx, x.arg, x.cmd};
        do @(posedge clk); while (!s_ready);
        predict_card_transfer(x);
        n_in++;
        if (counted) begin
            n_counted++;
        end
    endtask

    task automatic send_issue(input logic [5:0] cmd, input logic [31:0] arg);
        t_xfer x;
        x.req = REQ_ISSUE;
        x.cmd = cmd;
        x.arg = arg;
        x.rx  = 8'($urandom_range(255));
        send_xfer(x, 1'b1);
    endtask

    task automatic send_rx(input logic [7:0] b, input bit counted);
        t_xfer x;
        x.req = REQ_RX;
        x.cmd = 6'($urandom_range(63));
        x.arg = $urandom;
        x.rx  = b;
        send_xfer(x, counted);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_byte_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        byte_addr = mode;
        n_cfg++;
    endtask

    // one command with its response and, for reads, the data phase; sometimes one to four stray received bytes instead
    task automatic drive_command_sequence();
        int          sel;
        int          len;
        bit          full;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  r1;
        logic [7:0]  b;
        logic [15:0] crc;
        sel = $urandom_range(99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)), 1'b1);
            return;
        end
        if (sel < 30) cmd = CMD_READ_BLK;
        else if (sel < 45) cmd = CMD_SEND_CSD;
        else if (sel < 60) cmd = CMD_SEND_CID;
        else if (sel < 68) cmd = CMD_WRITE_BLK;
        else cmd = 6'($urandom_range(63));
        case ($urandom_range(9))
            0: arg = 32'h0;
            1: arg = 32'hffffffff;
            default: arg = $urandom;
        endcase
        send_issue(cmd, arg);
        repeat ($urandom_range(0, 3)) send_rx(8'h80 | 8'($urandom_range(127)), 1'b1);
        r1 = ($urandom_range(3) != 0) ? 8'h00 : 8'($urandom_range(127));
        send_rx(r1, 1'b1);
        if (!(cmd == CMD_SEND_CSD || cmd == CMD_SEND_CID || (cmd == CMD_READ_BLK && r1 == 0))) begin
            return;
        end
        repeat ($urandom_range(0, 3)) send_rx(BYTE_IDLE, 1'b1);
        if ($urandom_range(9) == 0) begin
            send_rx(8'($urandom_range(255)), 1'b1);
            return;
        end
        send_rx(TOKEN_START, 1'b1);
        len  = (cmd == CMD_READ_BLK) ? BLOCK_BYTES : REGISTER_BYTES;
        full = 1'b1;
        // block reads are cut short to keep the item count near the budget
        if (cmd == CMD_READ_BLK || $urandom_range(9) == 0) begin
            len  = $urandom_range(1, 20);
            full = 1'b0;
        end
        crc = '0;
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(255));
            crc = ccitt_next(crc, b);
            send_rx(b, 1'b1);
        end
        if (!full) begin
            return;
        end
        n_full_reads++;
        if ($urandom_range(4) == 0) begin
            crc ^= 16'(1 << $urandom_range(15));
        end
        send_rx(crc[15:8], 1'b1);
        send_rx(crc[7:0], 1'b1);
    endtask

    task automatic run_random_phase(input logic mode, input int idle_pct, input int stall,
                                    input bit hold);
        int start;
        drain_results();
        write_byte_mode(mode);
        send_idle_pct = idle_pct;
        stall_pct <= stall;
        if (hold) begin
            hold_arm <= 1'b1;
        end
        start = n_counted;
        while (n_counted - start < PHASE_ITEMS) begin
            drive_command_sequence();
        end
    endtask

    initial begin
        t_xfer x;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_byte_mode(1'b0);
        for (int i = 0; i < DIR_ROWS; i++) begin
            x.req = dir_rows[i].req;
            x.cmd = dir_rows[i].cmd;
            x.arg = dir_rows[i].arg;
            x.rx  = dir_rows[i].rx;
            send_xfer(x, 1'b1);
            if (dir_rows[i].typed) begin
                pending_results[pending_results.size() - 1] = '{dir_rows[i].kind,
                    dir_rows[i].octet, dir_rows[i].status, dir_rows[i].last_b};
            end
        end
        run_random_phase(1'b1, 0, 0, 1'b1);
        run_random_phase(1'b0, 77, 0, 1'b0);
        run_random_phase(1'b1, 0, 77, 1'b0);
        run_random_phase(1'b0, 26, 26, 1'b0);
        drain_results();
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("tb_top: %0d transfers in, %0d results checked, %0d reads with CRC check",
                 n_in, n_checked, n_full_reads);
        $display("tb_top: %0d byte-mode writes, idle/stall phases and one long output hold-off",
                 n_cfg);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
